FILE: rtl/cbq_pkg.sv
// shared types and constants for the coalescing bounded queue
package cbq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int OUT_HDL_W   = 16;
   localparam int EVICT_W     = 16;

   localparam logic [1:0] OP_PUSH       = 2'd0;
   localparam logic [1:0] OP_PUSH_KEYED = 2'd1;
   localparam logic [1:0] OP_TAKE       = 2'd2;

   localparam logic [EVICT_W-1:0] COUNT_MAX = {EVICT_W{1'b1}};

   typedef struct packed {
      logic [1:0]           op;
      logic [KEY_W-1:0]     key;
      logic [OUT_HDL_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic                 taken_valid;
      logic [OUT_HDL_W-1:0] taken_handle;
      logic                 evicted_oldest;
      logic [EVICT_W-1:0]   drop_report;
      logic [4:0]           fill_level;
   } rsp_type;

endpackage

FILE: rtl/coalescing_bounded_queue.sv
// coalescing bounded queue: top level with scan sequencer and entry store
//
// usage: a request item on req_* is a plain push, a keyed push or a take.
// every request item yields exactly one response item on rsp_*.
// req_ready is high only while the sequencer is idle; one item is in work
// at a time.
// a plain push, a take or a push with a null handle goes straight from
// acceptance to the finish step, which loads the response register and
// returns the sequencer to idle.
// a keyed push first scans the queue with one key comparator, one entry a
// cycle, rotating survivors to the tail, and then goes to the finish step.
// full pushes drop the head and bump a saturating 16-bit drop counter;
// a take on an empty queue reports that counter and clears it.
// the response sits in an output register; a new request can be accepted
// while it waits, and the sequencer holds its final step until the
// register is free, so a stalled receiver stalls the block.
// synchronous reset empties the queue, clears the counter and drops any
// pending response.
module coalescing_bounded_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbq_pkg::rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam int D  = cbq_pkg::QUEUE_DEPTH;
   localparam int HW = cbq_pkg::HANDLE_BITS;
   localparam int KW = cbq_pkg::KEY_W;
   localparam int IW = cbq_pkg::IDX_W;
   localparam int CW = cbq_pkg::CNT_W;

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic [KW-1:0]              key_ff, key_in;
   logic [HW-1:0]              hdl_ff, hdl_in;
   logic [HW-1:0]              ent_hdl_ff [D];
   logic [HW-1:0]              ent_hdl_in [D];
   logic [KW-1:0]              ent_key_ff [D];
   logic [KW-1:0]              ent_key_in [D];
   logic [D-1:0]               ent_keyed_ff, ent_keyed_in;
   logic [CW-1:0]              occ_ff, occ_in;
   logic [CW-1:0]              scan_cnt_ff, scan_cnt_in;
   logic [cbq_pkg::EVICT_W-1:0] evict_cnt_ff, evict_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cbq_pkg::rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0] occ_m1;
   logic [HW-1:0] req_hdl;
   logic          head_match;
   logic          is_push;
   logic          rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign occ_m1     = occ_ff - CW'(1);
   assign req_hdl    = HW'(req_data.handle);
   assign head_match = ent_keyed_ff[0] && (ent_key_ff[0] == key_ff);
   assign is_push    = ((op_ff == cbq_pkg::OP_PUSH) || (op_ff == cbq_pkg::OP_PUSH_KEYED))
                       && (hdl_ff != '0);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      hdl_in       = hdl_ff;
      ent_hdl_in   = ent_hdl_ff;
      ent_key_in   = ent_key_ff;
      ent_keyed_in = ent_keyed_ff;
      occ_in       = occ_ff;
      scan_cnt_in  = scan_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.op;
               key_in = req_data.key;
               hdl_in = req_hdl;
               if ((req_data.op == cbq_pkg::OP_PUSH_KEYED) && (req_hdl != '0)
                   && (occ_ff != '0)) begin
                  scan_cnt_in = occ_ff;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            // rotate the head out; survivors go back in at the tail
            for (int i = 0; i < D - 1; i++) begin
               ent_hdl_in[i]   = ent_hdl_ff[i + 1];
               ent_key_in[i]   = ent_key_ff[i + 1];
               ent_keyed_in[i] = ent_keyed_ff[i + 1];
            end
            if (head_match) begin
               occ_in = occ_m1;
            end else begin
               ent_hdl_in[occ_m1[IW-1:0]]   = ent_hdl_ff[0];
               ent_key_in[occ_m1[IW-1:0]]   = ent_key_ff[0];
               ent_keyed_in[occ_m1[IW-1:0]] = ent_keyed_ff[0];
            end
            scan_cnt_in = scan_cnt_ff - CW'(1);
            if (scan_cnt_ff == CW'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (is_push) begin
                  if (occ_ff == CW'(D)) begin
                     for (int i = 0; i < D - 1; i++) begin
                        ent_hdl_in[i]   = ent_hdl_ff[i + 1];
                        ent_key_in[i]   = ent_key_ff[i + 1];
                        ent_keyed_in[i] = ent_keyed_ff[i + 1];
                     end
                     ent_hdl_in[D-1]   = hdl_ff;
                     ent_key_in[D-1]   = key_ff;
                     ent_keyed_in[D-1] = (op_ff == cbq_pkg::OP_PUSH_KEYED);
                     rsp_in.evicted_oldest = 1'b1;
                     if (evict_cnt_ff != cbq_pkg::COUNT_MAX) begin
                        evict_cnt_in = evict_cnt_ff + cbq_pkg::EVICT_W'(1);
                     end
                  end else begin
                     ent_hdl_in[occ_ff[IW-1:0]]   = hdl_ff;
                     ent_key_in[occ_ff[IW-1:0]]   = key_ff;
                     ent_keyed_in[occ_ff[IW-1:0]] = (op_ff == cbq_pkg::OP_PUSH_KEYED);
                     occ_in = occ_ff + CW'(1);
                  end
               end else if (op_ff == cbq_pkg::OP_TAKE) begin
                  if (occ_ff != '0) begin
                     rsp_in.taken_valid  = 1'b1;
                     rsp_in.taken_handle = cbq_pkg::OUT_HDL_W'(ent_hdl_ff[0]);
                     for (int i = 0; i < D - 1; i++) begin
                        ent_hdl_in[i]   = ent_hdl_ff[i + 1];
                        ent_key_in[i]   = ent_key_ff[i + 1];
                        ent_keyed_in[i] = ent_keyed_ff[i + 1];
                     end
                     occ_in = occ_m1;
                  end else begin
                     rsp_in.drop_report = evict_cnt_ff;
                     evict_cnt_in       = '0;
                  end
               end
               rsp_in.fill_level = 5'(occ_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ent_keyed_ff <= '0;
         occ_ff       <= '0;
         scan_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ent_keyed_ff <= ent_keyed_in;
         occ_ff       <= occ_in;
         scan_cnt_ff  <= scan_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      hdl_ff     <= hdl_in;
      ent_hdl_ff <= ent_hdl_in;
      ent_key_ff <= ent_key_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: tb/coalescing_bounded_queue_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the coalescing bounded queue with randomized handshakes
module coalescing_bounded_queue_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 620;
   localparam int OVERFLOW_PUSHES = 20;
   localparam int SETTLE_CYCLES = 30;

   typedef struct {
      logic [cbq_pkg::OUT_HDL_W-1:0] handle;
      logic [cbq_pkg::KEY_W-1:0]     key;
      logic                          keyed;
   } entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cbq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cbq_pkg::rsp_type rsp_data;

   cbq_pkg::req_type            req_backlog[$];
   cbq_pkg::rsp_type            rsp_owed[$];
   entry_type                   queued[$];
   logic [cbq_pkg::EVICT_W-1:0] drop_tally = '0;
   cbq_pkg::rsp_type            want;

   int   send_idle_pct = 36;
   int   recv_idle_pct = 55;
   int   fail_count = 0;
   int   items_in = 0;
   int   evictions = 0;
   int   coalesced = 0;
   int   reports = 0;

   coalescing_bounded_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cbq_pkg::rsp_type queue_step(cbq_pkg::req_type r);
      cbq_pkg::rsp_type res;
      entry_type        ent;
      res = '0;
      if ((r.op == cbq_pkg::OP_PUSH || r.op == cbq_pkg::OP_PUSH_KEYED) && r.handle != '0) begin
         if (r.op == cbq_pkg::OP_PUSH_KEYED) begin
            for (int i = queued.size() - 1; i >= 0; i--) begin
               if (queued[i].keyed && queued[i].key == r.key) begin
                  queued.delete(i);
                  coalesced++;
               end
            end
         end
         if (queued.size() >= cbq_pkg::QUEUE_DEPTH) begin
            queued.delete(0);
            res.evicted_oldest = 1'b1;
            evictions++;
            if (drop_tally != cbq_pkg::COUNT_MAX) drop_tally++;
         end
         ent.handle = r.handle;
         ent.key    = (r.op == cbq_pkg::OP_PUSH_KEYED) ? r.key : '0;
         ent.keyed  = (r.op == cbq_pkg::OP_PUSH_KEYED);
         queued.insert(queued.size(), ent);
      end else if (r.op == cbq_pkg::OP_TAKE) begin
         if (queued.size() > 0) begin
            ent = queued[0];
            queued.delete(0);
            res.taken_valid  = 1'b1;
            res.taken_handle = ent.handle;
         end else begin
            res.drop_report = drop_tally;
            if (drop_tally != '0) reports++;
            drop_tally = '0;
         end
      end
      res.fill_level = 5'(queued.size());
      return res;
   endfunction

   task automatic add_item(input logic [1:0] op, input logic [cbq_pkg::KEY_W-1:0] key,
                           input logic [cbq_pkg::OUT_HDL_W-1:0] handle);
      cbq_pkg::req_type r;
      r.op     = op;
      r.key    = key;
      r.handle = handle;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic add_random(input int count);
      int                            counted;
      int                            take_pct;
      int                            pick;
      logic [1:0]                    op;
      logic [cbq_pkg::KEY_W-1:0]     key;
      logic [cbq_pkg::OUT_HDL_W-1:0] handle;
      counted  = 0;
      take_pct = 30;
      while (counted < count) begin
         // switch at random between fill-heavy and drain-heavy stretches
         if (counted % 24 == 0) take_pct = ($urandom_range(1) == 1) ? 20 : 65;
         pick = $urandom_range(99);
         if (pick < take_pct) op = cbq_pkg::OP_TAKE;
         else if (pick < take_pct + 3) op = OP_UNUSED;
         else op = ($urandom_range(1) == 1) ? cbq_pkg::OP_PUSH_KEYED : cbq_pkg::OP_PUSH;
         if ($urandom_range(4) == 0) begin
            key = $urandom;
         end else begin
            case ($urandom_range(3))
               0: key = '0;
               1: key = '1;
               2: key = 32'h0000_0001;
               default: key = 32'hA5A5_5A5A;
            endcase
         end
         case ($urandom_range(15))
            0: handle = '0;
            1: handle = '1;
            default: handle = 16'($urandom_range(65535, 1));
         endcase
         add_item(op, key, handle);
         counted++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            rsp_owed.insert(rsp_owed.size(), queue_step(req_data));
            items_in++;
         end
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog[0];
            req_backlog.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_owed.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected item: valid %0d handle %h evict %0d drop %0d fill %0d",
                           rsp_data.taken_valid, rsp_data.taken_handle,
                           rsp_data.evicted_oldest, rsp_data.drop_report,
                           rsp_data.fill_level);
            end else begin
               want = rsp_owed[0];
               rsp_owed.delete(0);
               if (rsp_data.taken_valid !== want.taken_valid ||
                   rsp_data.taken_handle !== want.taken_handle ||
                   rsp_data.evicted_oldest !== want.evicted_oldest ||
                   rsp_data.drop_report !== want.drop_report ||
                   rsp_data.fill_level !== want.fill_level) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: exp valid %0d handle %h evict %0d drop %0d fill %0d",
                              want.taken_valid, want.taken_handle, want.evicted_oldest,
                              want.drop_report, want.fill_level);
                     $display("          got valid %0d handle %h evict %0d drop %0d fill %0d",
                              rsp_data.taken_valid, rsp_data.taken_handle,
                              rsp_data.evicted_oldest, rsp_data.drop_report,
                              rsp_data.fill_level);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_item(cbq_pkg::OP_TAKE, '1, '1);
      add_item(cbq_pkg::OP_PUSH, '0, '0);
      add_item(cbq_pkg::OP_PUSH_KEYED, '1, '0);
      add_item(OP_UNUSED, '1, '1);
      add_item(cbq_pkg::OP_PUSH, '1, 16'hFFFF);
      add_item(cbq_pkg::OP_PUSH_KEYED, '0, 16'h0001);
      add_item(cbq_pkg::OP_PUSH_KEYED, '1, 16'h8000);
      add_item(cbq_pkg::OP_PUSH_KEYED, '0, 16'h0002);
      add_item(cbq_pkg::OP_PUSH, '0, 16'h7FFF);
      add_item(cbq_pkg::OP_TAKE, '0, '0);
      for (int i = 0; i < 14; i++) add_item(cbq_pkg::OP_PUSH, '1, 16'(i + 3));
      add_item(cbq_pkg::OP_PUSH_KEYED, '0, 16'h5A5A);

      add_random(RANDOM_ITEMS / 3);
      while (req_backlog.size() != 0) @(posedge clock);
      send_idle_pct = 55;
      recv_idle_pct = 36;
      add_random(RANDOM_ITEMS / 3);
      while (req_backlog.size() != 0) @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      // drain, clear the count, overflow, then drain and report the drops
      repeat (cbq_pkg::QUEUE_DEPTH + 1) add_item(cbq_pkg::OP_TAKE, '0, '0);
      repeat (OVERFLOW_PUSHES)
         add_item(cbq_pkg::OP_PUSH, $urandom, 16'($urandom_range(65535, 1)));
      repeat (cbq_pkg::QUEUE_DEPTH + 2) add_item(cbq_pkg::OP_TAKE, $urandom, 16'($urandom));

      while (req_backlog.size() != 0 || req_valid || rsp_owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("items %0d, evictions %0d, coalesced entries %0d, nonzero drop reports %0d",
               items_in, evictions, coalesced, reports);
      $display("mixed pushes, keyed replacement, overflow and empty takes; failures: %0d",
               fail_count);
      if (fail_count == 0 && rsp_owed.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d items outstanding", rsp_owed.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
